// ----- rtl/bchpd_pkg.sv -----
// Shared types, constants and syndrome functions for the BCH(31,21) parity decoder.
`timescale 1ns / 1ps

package bchpd_pkg;

    // Word geometry: 31 code bits above one even-parity bit.
    localparam int WORD_W = 32;
    localparam int CODE_W = 31;
    localparam int SYN_W  = 10;
    localparam int CNT_W  = 2;

    // Generator polynomial x^10+x^9+x^8+x^6+x^5+x^3+1.
    localparam logic [SYN_W:0] GEN_POLY = 11'h769;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_CLEAN = 2'd0,
        ST_FIXED = 2'd1,
        ST_FAIL  = 2'd2
    } status_t;

    // Error count reported for a word beyond correction.
    localparam logic [CNT_W-1:0] CNT_FAIL = 2'd3;

    typedef logic [SYN_W-1:0] syn_t;
    typedef syn_t syn_table_t [CODE_W];

    // Remainder of a 31-bit polynomial by the generator; used at elaboration only.
    function automatic syn_t poly_remainder(logic [CODE_W-1:0] poly);
        logic [CODE_W-1:0] rem;
        rem = poly;
        for (int k = CODE_W - 1; k >= SYN_W; k--) begin
            if (rem[k]) begin
                rem = rem ^ (CODE_W'(GEN_POLY) << (k - SYN_W));
            end
        end
        return rem[SYN_W-1:0];
    endfunction

    // Syndrome of each single-bit error position.
    function automatic syn_table_t build_bit_syn();
        syn_table_t tbl;
        for (int a = 0; a < CODE_W; a++) begin
            tbl[a] = poly_remainder(CODE_W'(1) << a);
        end
        return tbl;
    endfunction

    localparam syn_table_t BIT_SYN = build_bit_syn();

    // The syndrome is linear: XOR of the per-bit syndromes of all set bits.
    function automatic syn_t code_syndrome(logic [CODE_W-1:0] code);
        syn_t syn;
        syn = '0;
        for (int k = 0; k < CODE_W; k++) begin
            if (code[k]) begin
                syn = syn ^ BIT_SYN[k];
            end
        end
        return syn;
    endfunction

    // Request entering the error locator.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        syn_t              syn;
    } syn_item_t;

    // Request leaving the error locator.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              syn_nz;
        logic [CODE_W-1:0] pattern;
        logic              single_hit;
        logic              pair_hit;
    } loc_item_t;

endpackage

// ----- rtl/bch_31_21_parity_decoder_core.sv -----
// Top level of the BCH(31,21) decoder with overall even parity.
//
//  Channel   Dir  Signals                    Content (lowest bit first)
//  s_axis    in   tvalid tready tdata[31:0]  received_word
//  m_axis    out  tvalid tready tdata[39:0]  corrected_word, error_count, 6 zero bits
//                 tuser[1:0]                 status
//
// Four register stages lie between an accepted request and its result: syndrome, single-error
// match, double-error match, then repair and parity check.
// One request is taken every cycle while no stall holds it. The double-error compare across all bit positions
// sets the depth of the third stage. Reset clears only the valid bits; there is no
// table to load. A stall on m_axis holds every stage that is full and lets empty stages
// fill, so no request is lost or repeated.
`timescale 1ns / 1ps

module bch_31_21_parity_decoder_core
    import bchpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // received_word[31:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // corrected_word[31:0], error_count[33:32], zero[39:34]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    // Syndrome stage.
    logic              a_vld_reg, a_vld_next;
    syn_item_t         a_item_reg, a_item_next;
    logic              a_ready;

    // Locator handshake.
    logic              loc_in_ready;
    logic              loc_valid;
    loc_item_t         loc_item;

    // Output stage.
    logic              d_vld_reg, d_vld_next;
    logic              d_ready;
    logic [WORD_W-1:0] d_word_reg, d_word_next;
    status_t           d_status_reg, d_status_next;
    logic [CNT_W-1:0]  d_count_reg, d_count_next;

    assign d_ready       = !d_vld_reg || m_axis_tready;
    assign a_ready       = !a_vld_reg || loc_in_ready;
    assign s_axis_tready = a_ready;

    assign a_vld_next = a_ready ? s_axis_tvalid : a_vld_reg;
    assign d_vld_next = d_ready ? loc_valid : d_vld_reg;

    // Syndrome of the 31 code bits.
    always_comb
    begin
        a_item_next.word = s_axis_tdata;
        a_item_next.syn  = code_syndrome(s_axis_tdata[WORD_W-1:1]);
    end

    bchpd_locate u_locate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_vld_reg),
        .in_ready  (loc_in_ready),
        .in_item   (a_item_reg),
        .out_valid (loc_valid),
        .out_ready (d_ready),
        .out_item  (loc_item)
    );

    // Repair, parity check and final verdict.
    always_comb
    begin
        logic [CNT_W-1:0]  weight;
        logic              known;
        logic              odd;
        logic [CNT_W-1:0]  changed;
        logic [WORD_W-1:0] fixed;

        if (!loc_item.syn_nz)
        begin
            weight = 2'd0;
        end
        else if (loc_item.single_hit)
        begin
            weight = 2'd1;
        end
        else if (loc_item.pair_hit)
        begin
            weight = 2'd2;
        end
        else
        begin
            weight = 2'd0;
        end
        known = !loc_item.syn_nz || loc_item.single_hit || loc_item.pair_hit;

        // Parity of the repaired word follows from the input parity and the pattern weight.
        fixed   = loc_item.word ^ {loc_item.pattern & {CODE_W{loc_item.syn_nz}}, 1'b0};
        odd     = (^loc_item.word) ^ weight[0];
        fixed   = fixed ^ {{(WORD_W-1){1'b0}}, odd};
        changed = weight + {{(CNT_W-1){1'b0}}, odd};

        if (!known || changed == CNT_FAIL)
        begin
            d_word_next   = loc_item.word;
            d_status_next = ST_FAIL;
            d_count_next  = CNT_FAIL;
        end
        else
        begin
            d_word_next   = fixed;
            d_status_next = (changed != '0) ? ST_FIXED : ST_CLEAN;
            d_count_next  = changed;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
            d_vld_reg <= d_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (a_ready && s_axis_tvalid)
        begin
            a_item_reg <= a_item_next;
        end
        if (d_ready && loc_valid)
        begin
            d_word_reg   <= d_word_next;
            d_status_reg <= d_status_next;
            d_count_reg  <= d_count_next;
        end
    end

    assign m_axis_tvalid = d_vld_reg;
    assign m_axis_tdata  = {6'b000000, d_count_reg, d_word_reg};
    assign m_axis_tuser  = d_status_reg;

    // Status and error count must agree.
    a_fail_count: assert property (@(posedge clk) disable iff (!rst_n)
        d_vld_reg && d_status_reg == ST_FAIL |-> d_count_reg == CNT_FAIL)
        else $error("uncorrectable result without the failure count");

    a_clean_count: assert property (@(posedge clk) disable iff (!rst_n)
        d_vld_reg && d_status_reg == ST_CLEAN |-> d_count_reg == 2'd0)
        else $error("clean result with a nonzero error count");

    a_fixed_count: assert property (@(posedge clk) disable iff (!rst_n)
        d_vld_reg && d_status_reg == ST_FIXED |-> d_count_reg == 2'd1 || d_count_reg == 2'd2)
        else $error("corrected result with an impossible error count");

    // A full syndrome stage holds its request while the locator is blocked.
    a_syn_hold: assert property (@(posedge clk) disable iff (!rst_n)
        a_vld_reg && !loc_in_ready |=> a_vld_reg && $stable(a_item_reg))
        else $error("syndrome stage changed while stalled");

endmodule

// ----- rtl/bchpd_locate.sv -----
// Two-stage error locator: matches a syndrome against all one- and two-bit error patterns.
`timescale 1ns / 1ps

module bchpd_locate
    import bchpd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  syn_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output loc_item_t out_item
);

    // First stage: single-error hits and the syndrome left after removing each position.
    logic                b_vld_reg, b_vld_next;
    logic [WORD_W-1:0]   b_word_reg;
    logic                b_syn_nz_reg, b_syn_nz_next;
    logic [CODE_W-1:0]   b_hit1_reg, b_hit1_next;
    syn_table_t          b_delta_reg, b_delta_next;

    // Second stage: complete error pattern.
    logic                c_vld_reg, c_vld_next;
    loc_item_t           c_item_reg, c_item_next;

    logic                b_ready;
    logic                c_ready;
    logic [CODE_W-1:0]   pair_vec;

    // Each stage accepts when empty or when its contents move on.
    assign c_ready  = !c_vld_reg || out_ready;
    assign b_ready  = !b_vld_reg || c_ready;
    assign in_ready = b_ready;

    assign b_vld_next = b_ready ? in_valid : b_vld_reg;
    assign c_vld_next = c_ready ? b_vld_reg : c_vld_reg;

    // Compare the syndrome with every single-bit syndrome.
    always_comb
    begin
        b_syn_nz_next = (in_item.syn != '0);
        for (int j = 0; j < CODE_W; j++) begin
            b_hit1_next[j]  = (in_item.syn == BIT_SYN[j]);
            b_delta_next[j] = in_item.syn ^ BIT_SYN[j];
        end
    end

    // A position is part of a double error when its residual matches another position.
    always_comb
    begin
        for (int j = 0; j < CODE_W; j++) begin
            pair_vec[j] = 1'b0;
            for (int a = 0; a < CODE_W; a++) begin
                if (a != j && b_delta_reg[j] == BIT_SYN[a]) begin
                    pair_vec[j] = 1'b1;
                end
            end
        end
        c_item_next.word       = b_word_reg;
        c_item_next.syn_nz     = b_syn_nz_reg;
        c_item_next.pattern    = b_hit1_reg | pair_vec;
        c_item_next.single_hit = |b_hit1_reg;
        c_item_next.pair_hit   = |pair_vec;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= b_vld_next;
            c_vld_reg <= c_vld_next;
        end
    end

    // Payload registers load only when a request moves in.
    always_ff @(posedge clk)
    begin
        if (b_ready && in_valid)
        begin
            b_word_reg   <= in_item.word;
            b_syn_nz_reg <= b_syn_nz_next;
            b_hit1_reg   <= b_hit1_next;
            b_delta_reg  <= b_delta_next;
        end
        if (c_ready && b_vld_reg)
        begin
            c_item_reg <= c_item_next;
        end
    end

    assign out_valid = c_vld_reg;
    assign out_item  = c_item_reg;

    // The code has distance five, so the decoded pattern is unambiguous.
    a_single_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld_reg && c_item_reg.single_hit |-> $onehot(c_item_reg.pattern))
        else $error("single-error match without a one-hot pattern");

    a_pair_two_bits: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld_reg && c_item_reg.pair_hit |-> $countones(c_item_reg.pattern) == 2)
        else $error("double-error match without exactly two pattern bits");

    a_hits_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld_reg |-> !(c_item_reg.single_hit && c_item_reg.pair_hit))
        else $error("syndrome matched both a single and a double error");

endmodule
